FILE: rtl/rtcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RLC time-constant meter.
// Used by the controller, the datapath and the top level.
package rtcm_pkg;

    localparam logic [31:0] CAP_Q40  = 32'd204513;
    localparam logic [31:0] IND_LQ20 = 32'd2569416106;
    localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;

    localparam logic [2:0] MODE_R    = 3'd0;
    localparam logic [2:0] MODE_C    = 3'd1;
    localparam logic [2:0] MODE_L    = 3'd2;
    localparam logic [2:0] MODE_ESR  = 3'd3;
    localparam logic [2:0] MODE_AUTO = 3'd4;

    localparam logic [2:0] KIND_R    = 3'd0;
    localparam logic [2:0] KIND_C    = 3'd1;
    localparam logic [2:0] KIND_L    = 3'd2;
    localparam logic [2:0] KIND_ESR  = 3'd3;
    localparam logic [2:0] KIND_NONE = 3'd4;

    localparam logic [1:0] JOB_R = 2'd0;
    localparam logic [1:0] JOB_C = 2'd1;
    localparam logic [1:0] JOB_E = 2'd2;
    localparam logic [1:0] JOB_L = 2'd3;

    localparam logic [1:0] REG_DISCHARGE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_DIVISOR   = 2'd2;

    typedef struct packed {
        logic       clr_elapsed;
        logic       inc_elapsed;
        logic       mul_load;
        logic       zero_prod;
        logic       set_flag;
        logic       clr_flag;
        logic       sample_load;
        logic       div_start;
        logic       finish;
        logic       out_load;
        logic [1:0] job;
        logic [2:0] active_mode;
    } rtcm_cmd_t;

    typedef struct packed {
        logic dis_done;
        logic over_timeout;
        logic div_busy;
        logic div_done;
        logic sample_zero;
        logic l_timed_out;
        logic out_free;
    } rtcm_status_t;

endpackage

FILE: rtl/rtcm_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, 64-bit dividend by 12-bit divisor, one bit a cycle.
// Standalone; used by the datapath.
module rtcm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [11:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [12:0] shifted;
    logic        qbit;

    always_comb begin
        shifted = {rem_reg, quo_reg[63]};
        qbit    = (shifted >= {1'b0, div_reg});
        if (qbit) begin
            rem_next = 12'(shifted - {1'b0, div_reg});
        end else begin
            rem_next = shifted[11:0];
        end
        quo_next = {quo_reg[62:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = run_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/rtcm_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, tick counter, multiplier, divider, saved results, output register.
// Depends on rtcm_pkg and rtcm_div.
module rtcm_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtcm_pkg::rtcm_cmd_t   cmd,
    output rtcm_pkg::rtcm_status_t status,
    input  logic [11:0]           adc_sample,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic [3:0]            m_tuser
);

    logic [31:0] dis_reg, tmo_reg;
    logic [7:0]  rdiv_reg;
    logic [31:0] elapsed_reg;
    logic [63:0] prod_reg;
    logic [11:0] sample_reg;
    logic [31:0] esr_reg, res_r_reg, res_c_reg, res_l_reg;
    logic [1:0]  flags_reg;
    logic        mval_reg;
    logic [31:0] mdata_reg;
    logic [3:0]  muser_reg;

    logic [63:0] div_dividend;
    logic [11:0] div_divisor;
    logic [63:0] quo;
    logic        div_busy, div_done;
    logic [12:0] esr_diff;
    logic [17:0] esr_num;
    logic [31:0] mul_const;
    logic [31:0] q32, r_val, l_val;
    logic [2:0]  o_kind;
    logic [31:0] o_value;
    logic        o_to;
    logic        cto, lto;
    logic        flag_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dis_reg  <= 32'd40000000;
            tmo_reg  <= 32'd833333333;
            rdiv_reg <= 8'd57;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rtcm_pkg::REG_DISCHARGE: dis_reg  <= cfg_data;
                rtcm_pkg::REG_TIMEOUT:   tmo_reg  <= cfg_data;
                rtcm_pkg::REG_DIVISOR:   rdiv_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign esr_diff  = 13'd4096 - {1'b0, sample_reg};
    assign esr_num   = {esr_diff, 5'd0} + {5'd0, esr_diff};
    assign mul_const = (cmd.job == rtcm_pkg::JOB_C) ? rtcm_pkg::CAP_Q40 : rtcm_pkg::IND_LQ20;
    assign flag_bit  = (cmd.job == rtcm_pkg::JOB_L);

    always_comb begin
        unique case (cmd.job)
            rtcm_pkg::JOB_R: begin
                div_dividend = {32'd0, elapsed_reg};
                div_divisor  = (rdiv_reg == 8'd0) ? 12'd1 : {4'd0, rdiv_reg};
            end
            rtcm_pkg::JOB_E: begin
                div_dividend = {46'd0, esr_num};
                div_divisor  = sample_reg;
            end
            default: begin
                div_dividend = prod_reg;
                div_divisor  = sample_reg;
            end
        endcase
    end

    rtcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    assign q32   = quo[31:0];
    assign r_val = (q32 == rtcm_pkg::U32_MAX) ? q32 : q32 + 32'd1;

    always_comb begin
        if (flags_reg[1]) begin
            l_val = '0;
        end else if (sample_reg == 12'd0 || quo[63:52] != 12'd0) begin
            l_val = rtcm_pkg::U32_MAX;
        end else begin
            l_val = quo[51:20];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            flags_reg   <= '0;
            sample_reg  <= '0;
            esr_reg     <= '0;
            res_r_reg   <= '0;
            res_c_reg   <= '0;
            res_l_reg   <= '0;
        end else begin
            if (cmd.clr_elapsed) begin
                elapsed_reg <= '0;
            end else if (cmd.inc_elapsed && elapsed_reg != rtcm_pkg::U32_MAX) begin
                elapsed_reg <= elapsed_reg + 32'd1;
            end
            if (cmd.set_flag) begin
                flags_reg[flag_bit] <= 1'b1;
            end else if (cmd.clr_flag) begin
                flags_reg[flag_bit] <= 1'b0;
            end
            if (cmd.sample_load) begin
                sample_reg <= adc_sample;
            end
            if (cmd.finish) begin
                unique case (cmd.job)
                    rtcm_pkg::JOB_R: res_r_reg <= r_val;
                    rtcm_pkg::JOB_C: res_c_reg <= {22'd0, prod_reg[49:40]};
                    rtcm_pkg::JOB_E: esr_reg   <= (sample_reg == 12'd0) ?
                                                  rtcm_pkg::U32_MAX : q32;
                    rtcm_pkg::JOB_L: res_l_reg <= l_val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_reg <= elapsed_reg * mul_const;
        end else if (cmd.zero_prod) begin
            prod_reg <= '0;
        end
    end

    assign cto = flags_reg[0];
    assign lto = flags_reg[1];

    always_comb begin
        o_kind  = rtcm_pkg::KIND_NONE;
        o_value = '0;
        o_to    = 1'b0;
        unique case (cmd.job)
            rtcm_pkg::JOB_R: begin
                o_kind  = rtcm_pkg::KIND_R;
                o_value = res_r_reg;
            end
            rtcm_pkg::JOB_C: begin
                o_kind  = rtcm_pkg::KIND_C;
                o_value = res_c_reg;
                o_to    = cto;
            end
            rtcm_pkg::JOB_E: begin
                o_kind  = rtcm_pkg::KIND_ESR;
                o_value = esr_reg;
            end
            default: begin
                if (cmd.active_mode == rtcm_pkg::MODE_L) begin
                    o_kind  = rtcm_pkg::KIND_L;
                    o_value = res_l_reg;
                    o_to    = lto;
                end else if (cto && lto) begin
                    o_kind  = rtcm_pkg::KIND_R;
                    o_value = res_r_reg;
                end else if ((lto || res_l_reg > 32'd200) && res_r_reg < 32'd10) begin
                    o_kind  = rtcm_pkg::KIND_C;
                    o_value = cto ? 32'd0 : res_c_reg;
                    o_to    = cto;
                end else if (cto && res_r_reg < 32'd100) begin
                    o_kind  = rtcm_pkg::KIND_L;
                    o_value = res_l_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mval_reg <= 1'b1;
        end else if (m_tready) begin
            mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mdata_reg <= o_value;
            muser_reg <= {o_to, o_kind};
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    assign status.dis_done     = ({1'b0, elapsed_reg} + 33'd1) >= {1'b0, dis_reg};
    assign status.over_timeout = elapsed_reg > tmo_reg;
    assign status.div_busy     = div_busy;
    assign status.div_done     = div_done;
    assign status.sample_zero  = (sample_reg == 12'd0);
    assign status.l_timed_out  = lto;
    assign status.out_free     = !mval_reg || m_tready;

endmodule

FILE: rtl/rtcm_ctrl.sv
`timescale 1ns / 1ps
// Controller: measurement sequence state machine issuing datapath commands.
// Depends on rtcm_pkg.
module rtcm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   start_req,
    input  logic [2:0]             mode,
    input  logic                   comparator_tripped,
    input  rtcm_pkg::rtcm_status_t status,
    output rtcm_pkg::rtcm_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIS_R  = 4'd1;
    localparam logic [3:0] ST_TIME_R = 4'd2;
    localparam logic [3:0] ST_DIS_C  = 4'd3;
    localparam logic [3:0] ST_TIME_C = 4'd4;
    localparam logic [3:0] ST_DIS_E  = 4'd5;
    localparam logic [3:0] ST_SAMPLE = 4'd6;
    localparam logic [3:0] ST_DIS_L  = 4'd7;
    localparam logic [3:0] ST_TIME_L = 4'd8;
    localparam logic [3:0] ST_MUL    = 4'd9;
    localparam logic [3:0] ST_DIV    = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] mode_reg, mode_next;
    logic [1:0] job_reg, job_next;
    logic       acc;
    logic       emit_now;

    assign s_tready = (state_reg <= ST_TIME_L);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        emit_now = 1'b0;
        unique case (job_reg)
            rtcm_pkg::JOB_R: emit_now = (mode_reg == rtcm_pkg::MODE_R);
            rtcm_pkg::JOB_C: emit_now = (mode_reg == rtcm_pkg::MODE_C);
            rtcm_pkg::JOB_E: emit_now = (mode_reg == rtcm_pkg::MODE_ESR);
            default:         emit_now = 1'b1;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        job_next   = job_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc && start_req && mode <= rtcm_pkg::MODE_AUTO) begin
                    mode_next       = mode;
                    cmd.clr_elapsed = 1'b1;
                    if (mode == rtcm_pkg::MODE_R || mode == rtcm_pkg::MODE_AUTO) begin
                        state_next = ST_DIS_R;
                    end else if (mode == rtcm_pkg::MODE_C) begin
                        state_next = ST_DIS_C;
                    end else begin
                        state_next = ST_DIS_E;
                    end
                end
            end
            ST_DIS_R, ST_DIS_C, ST_DIS_E, ST_DIS_L: begin
                if (acc) begin
                    if (status.dis_done) begin
                        cmd.clr_elapsed = 1'b1;
                        state_next      = state_reg + 4'd1;
                    end else begin
                        cmd.inc_elapsed = 1'b1;
                    end
                end
            end
            ST_TIME_R: begin
                if (acc) begin
                    if (comparator_tripped) begin
                        job_next      = rtcm_pkg::JOB_R;
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.inc_elapsed = 1'b1;
                    end
                end
            end
            ST_TIME_C, ST_TIME_L: begin
                if (acc) begin
                    job_next = (state_reg == ST_TIME_C) ? rtcm_pkg::JOB_C : rtcm_pkg::JOB_L;
                    if (comparator_tripped) begin
                        cmd.mul_load = 1'b1;
                        cmd.clr_flag = 1'b1;
                        state_next   = ST_MUL;
                    end else if (status.over_timeout) begin
                        cmd.zero_prod = 1'b1;
                        cmd.set_flag  = 1'b1;
                        state_next    = ST_MUL;
                    end else begin
                        job_next        = job_reg;
                        cmd.inc_elapsed = 1'b1;
                    end
                end
            end
            ST_SAMPLE: begin
                if (acc) begin
                    job_next        = rtcm_pkg::JOB_E;
                    cmd.sample_load = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                if (job_reg == rtcm_pkg::JOB_C || status.sample_zero ||
                    (job_reg == rtcm_pkg::JOB_L && status.l_timed_out)) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                if (emit_now) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.clr_elapsed = 1'b1;
                    unique case (job_reg)
                        rtcm_pkg::JOB_R: state_next = ST_DIS_C;
                        rtcm_pkg::JOB_C: state_next = ST_DIS_E;
                        default:         state_next = ST_DIS_L;
                    endcase
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.job         = job_next;
        cmd.active_mode = mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= '0;
            job_reg   <= rtcm_pkg::JOB_R;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            job_reg   <= job_next;
        end
    end

endmodule

FILE: rtl/rlc_time_constant_meter.sv
`timescale 1ns / 1ps
// Top level of the RLC time-constant meter: controller, datapath and ports.
// Depends on rtcm_pkg, rtcm_ctrl and rtcm_datapath.
//
// Each input transaction is one timer tick. Discharge and timing ticks are taken one per
// clock. A tick that ends a timed step or samples the ADC closes input while the result
// is worked out: capacitance passes the multiply and finish states, resistance the divide
// and finish states, and ESR and inductance the multiply, divide and finish states. The
// shared divider retires one quotient bit per cycle over a 64-bit dividend. A reported
// result then passes the emit state, which places it in the output register; a step that
// only feeds a later step skips it. A zero ADC sample, or an inductance timeout, skips the
// divider. A result waits in the output register without blocking further ticks. The next
// result that is ready holds input closed until the waiting one is taken.
module rlc_time_constant_meter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // start_req, comparator_tripped, adc_sample[11:0], pad
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value
    output logic [3:0]  m_tuser,   // reported_kind[2:0], timed_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rtcm_pkg::rtcm_cmd_t    cmd;
    rtcm_pkg::rtcm_status_t status;

    assign cfg_ready = 1'b1;

    rtcm_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .start_req          (s_tdata[0]),
        .mode               (s_tuser),
        .comparator_tripped (s_tdata[1]),
        .status             (status),
        .cmd                (cmd)
    );

    rtcm_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .adc_sample (s_tdata[13:2]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_busy |-> !s_tready)
        else $error("input taken while divider busy");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output overwritten");

    a_div_start_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !s_tready)
        else $error("input open after divider start");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of rlc_time_constant_meter: random ticks and measurements,
// checked against a cycle-free prediction kept in a small scoreboard class.
// Depends on rtcm_pkg and the RTL of the meter.
module tb;

    localparam int STALL_LIMIT = 5000;

    class meter_scoreboard;
        typedef enum logic [3:0] {
            IDLE, DIS_R, TIME_R, DIS_C, TIME_C, DIS_E, SAMPLE, DIS_L, TIME_L
        } step_e;
        typedef struct {
            logic [2:0]  kind;
            logic [31:0] value;
            logic        timed_out;
        } reading_t;

        reading_t    readings_due[$];
        step_e       step;
        logic [2:0]  run_mode;
        logic [31:0] elapsed, esr_ohms, esr_sample, r_ohms, c_uf, l_uh;
        logic [1:0]  flags;
        logic [31:0] discharge, timeout;
        logic [7:0]  divisor;
        int          errors;

        function new();
            discharge = 32'd40000000;
            timeout   = 32'd833333333;
            divisor   = 8'd57;
            step = IDLE;
            run_mode = rtcm_pkg::MODE_R;
            elapsed = 0; esr_ohms = 0; esr_sample = 0;
            r_ohms = 0; c_uf = 0; l_uh = 0; flags = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                rtcm_pkg::REG_DISCHARGE: discharge = d;
                rtcm_pkg::REG_TIMEOUT:   timeout = d;
                rtcm_pkg::REG_DIVISOR:   divisor = d[7:0];
                default: ;
            endcase
        endfunction

        function void post(logic [2:0] kind, logic [31:0] value, logic to);
            reading_t r;
            r.kind = kind; r.value = value; r.timed_out = to;
            readings_due.push_back(r);
            step = IDLE;
        endfunction

        function void advance(step_e s);
            step = s;
            elapsed = 0;
        endfunction

        function void count_up();
            if (elapsed != rtcm_pkg::U32_MAX) elapsed++;
        endfunction

        function logic [31:0] inductance();
            logic [63:0] q;
            if (esr_sample == 0) return rtcm_pkg::U32_MAX;
            q = (64'(elapsed) * 64'(rtcm_pkg::IND_LQ20)) / 64'(esr_sample);
            q = q >> 20;
            return (q > 64'(rtcm_pkg::U32_MAX)) ? rtcm_pkg::U32_MAX : q[31:0];
        endfunction

        function void classify();
            logic cto, lto;
            cto = flags[0];
            lto = flags[1];
            if (cto && lto)
                post(rtcm_pkg::KIND_R, r_ohms, 1'b0);
            else if ((lto || l_uh > 200) && r_ohms < 10)
                post(rtcm_pkg::KIND_C, cto ? 32'd0 : c_uf, cto);
            else if (cto && r_ohms < 100)
                post(rtcm_pkg::KIND_L, l_uh, 1'b0);
            else
                post(rtcm_pkg::KIND_NONE, 32'd0, 1'b0);
        endfunction

        function void note_tick(logic start, logic [2:0] mode, logic cmp, logic [11:0] adc);
            logic [31:0] d, v;
            case (step)
                IDLE: begin
                    if (start && mode <= rtcm_pkg::MODE_AUTO) begin
                        run_mode = mode;
                        case (mode)
                            rtcm_pkg::MODE_C:                    advance(DIS_C);
                            rtcm_pkg::MODE_L, rtcm_pkg::MODE_ESR: advance(DIS_E);
                            default:                             advance(DIS_R);
                        endcase
                    end
                end
                DIS_R, DIS_C, DIS_E, DIS_L: begin
                    if (64'(elapsed) + 1 >= 64'(discharge))
                        advance(step_e'(step + 1));
                    else
                        elapsed++;
                end
                TIME_R: begin
                    if (!cmp) begin
                        count_up();
                    end else begin
                        d = (divisor == 0) ? 32'd1 : 32'(divisor);
                        v = elapsed / d;
                        if (v != rtcm_pkg::U32_MAX) v++;
                        r_ohms = v;
                        if (run_mode == rtcm_pkg::MODE_R) post(rtcm_pkg::KIND_R, v, 1'b0);
                        else advance(DIS_C);
                    end
                end
                TIME_C: begin
                    if (cmp || elapsed > timeout) begin
                        if (cmp) begin
                            c_uf = 32'((64'(elapsed) * 64'(rtcm_pkg::CAP_Q40)) >> 40);
                            flags[0] = 1'b0;
                        end else begin
                            c_uf = 0;
                            flags[0] = 1'b1;
                        end
                        if (run_mode == rtcm_pkg::MODE_C)
                            post(rtcm_pkg::KIND_C, c_uf, flags[0]);
                        else
                            advance(DIS_E);
                    end else begin
                        count_up();
                    end
                end
                SAMPLE: begin
                    esr_sample = 32'(adc);
                    esr_ohms = (adc != 0) ? (32'd33 * (32'd4096 - 32'(adc))) / 32'(adc)
                                          : rtcm_pkg::U32_MAX;
                    if (run_mode == rtcm_pkg::MODE_ESR)
                        post(rtcm_pkg::KIND_ESR, esr_ohms, 1'b0);
                    else
                        advance(DIS_L);
                end
                TIME_L: begin
                    if (cmp || elapsed > timeout) begin
                        if (cmp) begin
                            l_uh = inductance();
                            flags[1] = 1'b0;
                        end else begin
                            l_uh = 0;
                            flags[1] = 1'b1;
                        end
                        if (run_mode == rtcm_pkg::MODE_L)
                            post(rtcm_pkg::KIND_L, l_uh, flags[1]);
                        else
                            classify();
                    end else begin
                        count_up();
                    end
                end
                default: step = IDLE;
            endcase
        endfunction

        function void check(logic [2:0] kind, logic [31:0] value, logic to);
            reading_t r;
            if (readings_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d value %0d timed_out %0d",
                             kind, value, to);
                return;
            end
            r = readings_due.pop_front();
            if (r.kind !== kind || r.value !== value || r.timed_out !== to) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected kind %0d value %0d timed_out %0d, got %0d %0d %0d",
                             r.kind, r.value, r.timed_out, kind, value, to);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    meter_scoreboard sb;
    int  idle_cycles;
    int  items;
    int  rx_stall;
    bit  full_speed;

    rlc_time_constant_meter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_tick(s_tdata[0], s_tuser, s_tdata[1], s_tdata[13:2]);
            if (m_tvalid && m_tready)
                sb.check(m_tuser[2:0], m_tdata, m_tuser[3]);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || full_speed) begin
            m_tready = aresetn;
        end else if (rx_stall > 0) begin
            m_tready = 1'b0;
            rx_stall--;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: rx_stall = $urandom_range(1, 3);
                3:       rx_stall = $urandom_range(20, 60);
                default: rx_stall = 0;
            endcase
            m_tready = (rx_stall == 0);
        end
    end

    function automatic int pick_gap();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: return $urandom_range(1, 3);
            5:             return $urandom_range(10, 40);
            default:       return 0;
        endcase
    endfunction

    function automatic logic [11:0] pick_adc();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(1, 15));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send(bit start, logic [2:0] mode, bit cmp, logic [11:0] adc);
        int g;
        g = full_speed ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, adc, cmp, start};
        s_tuser  = mode;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items++;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Finish any measurement in flight, drain results, then let the divider go quiet.
    task automatic settle();
        while (sb.step != meter_scoreboard::IDLE)
            send(1'b0, rtcm_pkg::MODE_R, 1'b1, pick_adc());
        s_tvalid = 1'b0;
        while (sb.readings_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Start a measurement, hold the comparator low for hold ticks, trip, repeat until idle.
    // adc_sel below zero picks a random sample on every tick.
    task automatic measure(logic [2:0] mode, int hold, int adc_sel, bit busy_start);
        int k;
        logic [11:0] a;
        a = (adc_sel < 0) ? pick_adc() : 12'(adc_sel);
        send(1'b1, mode, 1'($urandom_range(0, 1)), a);
        while (sb.step != meter_scoreboard::IDLE) begin
            for (k = 0; k < hold && sb.step != meter_scoreboard::IDLE; k++) begin
                a = (adc_sel < 0) ? pick_adc() : 12'(adc_sel);
                send(busy_start, 3'($urandom_range(0, 7)), 1'b0, a);
            end
            if (sb.step != meter_scoreboard::IDLE) begin
                a = (adc_sel < 0) ? pick_adc() : 12'(adc_sel);
                send(busy_start, 3'($urandom_range(0, 7)), 1'b1, a);
            end
        end
    endtask

    task automatic random_phase(int n, logic [31:0] dis, logic [31:0] tmo, logic [7:0] div);
        int i;
        int h;
        cfg_write(rtcm_pkg::REG_DISCHARGE, dis);
        cfg_write(rtcm_pkg::REG_TIMEOUT, tmo);
        cfg_write(rtcm_pkg::REG_DIVISOR, 32'(div));
        for (i = 0; i < n; i++) begin
            h = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 30);
            case ($urandom_range(0, 9))
                0:       send(1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              pick_adc());
                1:       measure(3'($urandom_range(5, 7)), h, -1, 1'b0);
                default: measure(3'($urandom_range(0, 4)), h, -1,
                                 1'($urandom_range(0, 1)));
            endcase
        end
        settle();
    endtask

    initial begin
        sb = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = rtcm_pkg::MODE_R;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rtcm_pkg::REG_DISCHARGE;
        cfg_data  = '0;
        idle_cycles = 0;
        items = 0;
        rx_stall = 0;
        full_speed = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Longest discharge and an unused index, exercised with idle ticks only.
        cfg_write(rtcm_pkg::REG_DISCHARGE, rtcm_pkg::U32_MAX);
        cfg_write(2'd3, 32'hDEAD_BEEF);
        send(1'b0, rtcm_pkg::MODE_C, 1'b1, 12'hFFF);
        send(1'b0, rtcm_pkg::MODE_L, 1'b0, 12'h000);
        settle();

        // Directed checks.
        cfg_write(rtcm_pkg::REG_DISCHARGE, 32'd1);
        cfg_write(rtcm_pkg::REG_TIMEOUT, 32'd5);
        cfg_write(rtcm_pkg::REG_DIVISOR, 32'd1);
        measure(rtcm_pkg::MODE_R, 3, 100, 1'b0);
        measure(rtcm_pkg::MODE_C, 2, 100, 1'b0);
        measure(rtcm_pkg::MODE_C, 9, 100, 1'b0);        // capacitance timeout
        measure(rtcm_pkg::MODE_ESR, 0, 0, 1'b0);        // zero sample saturates
        measure(rtcm_pkg::MODE_ESR, 0, 4095, 1'b0);
        measure(rtcm_pkg::MODE_ESR, 0, 1, 1'b0);
        measure(rtcm_pkg::MODE_L, 4, 0, 1'b0);
        measure(rtcm_pkg::MODE_L, 9, 2000, 1'b0);       // inductance timeout
        measure(rtcm_pkg::MODE_L, 3, 7, 1'b1);          // start while busy
        measure(rtcm_pkg::MODE_AUTO, 9, 100, 1'b0);     // both timed out
        measure(rtcm_pkg::MODE_AUTO, 2, 1, 1'b0);
        measure(3'd5, 0, 100, 1'b0);
        measure(3'd7, 0, 100, 1'b0);
        settle();

        cfg_write(rtcm_pkg::REG_DISCHARGE, 32'd0);
        cfg_write(rtcm_pkg::REG_TIMEOUT, 32'd0);
        cfg_write(rtcm_pkg::REG_DIVISOR, 32'd0);
        measure(rtcm_pkg::MODE_R, 2, 100, 1'b0);
        measure(rtcm_pkg::MODE_AUTO, 1, 3, 1'b0);
        settle();

        full_speed = 1'b1;
        random_phase(10, 32'd0, 32'd8, 8'd255);
        full_speed = 1'b0;
        random_phase(10, 32'd3, rtcm_pkg::U32_MAX, 8'd1);
        random_phase(10, 32'd1, 32'd0, 8'd57);
        random_phase(10, 32'd2, 32'd12, 8'd200);
        full_speed = 1'b1;
        random_phase(8, 32'd1, 32'd6, 8'd255);
        full_speed = 1'b0;
        random_phase(10, 32'd0, 32'd4, 8'($urandom_range(1, 255)));

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
